// ----- hw/rtl/affcc_pkg.sv -----
package affcc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COLOR_FRAC_BITS = 14;

    localparam int BORDER_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [BORDER_W-1:0] LEFT_BORDER_RST   = 16'hFE0C;
    localparam logic [BORDER_W-1:0] RIGHT_BORDER_RST  = 16'd1500;
    localparam logic [BORDER_W-1:0] TOP_BORDER_RST    = 16'hFE70;
    localparam logic [BORDER_W-1:0] BOTTOM_BORDER_RST = 16'd1200;

    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd3;

    localparam logic [1:0] TYPE_IDENT     = 2'd0;
    localparam logic [1:0] TYPE_TRANSLATE = 2'd1;
    localparam logic [1:0] TYPE_TSCALE    = 2'd2;
    localparam logic [1:0] TYPE_GENERAL   = 2'd3;

    localparam logic [1:0] MODE_COPY  = 2'd0;
    localparam logic [1:0] MODE_TRANS = 2'd1;
    localparam logic [1:0] MODE_FULL  = 2'd2;

    localparam logic [1:0] COL_NONE   = 2'd0;
    localparam logic [1:0] COL_PARENT = 2'd1;
    localparam logic [1:0] COL_LOCAL  = 2'd2;
    localparam logic [1:0] COL_MUL    = 2'd3;

    localparam int FLAG_MAT_CHG  = 0;
    localparam int FLAG_COL_CHG  = 1;
    localparam int FLAG_USE_PAR  = 2;
    localparam int FLAG_HAS_PAR  = 3;

    typedef struct packed {
        logic [3:0]  flags;
        logic [1:0]  parent_type;
        logic [1:0]  local_type;
        logic [63:0] parent_ab;
        logic [63:0] parent_cd;
        logic [63:0] parent_txy;
        logic [63:0] local_ab;
        logic [63:0] local_cd;
        logic [63:0] local_txy;
        logic [63:0] parent_color;
        logic [63:0] local_color;
    } in_word_t;

    typedef struct packed {
        logic        matrix_updated;
        logic [63:0] comp_ab;
        logic [63:0] comp_cd;
        logic [63:0] comp_txy;
        logic [1:0]  comp_type;
        logic        reject;
        logic        color_updated;
        logic [63:0] color_out;
    } out_word_t;

endpackage

// ----- hw/rtl/affine2d_compose_cull_color_unit.sv -----
// Composes a scene node's 2D affine matrix with its parent's, culls it against
// a border window and picks its effective colour.
// Input channel src_valid / src_stall / src_word: one node per word.
// Output channel dst_valid / dst_stall / dst_word: one result word per node.
// Config port cfg_wen / cfg_index / cfg_data writes the four borders
// (left, right, top, bottom); write only while no word is in flight.
// The pipeline has four register stages (input register, 32x32 multiplier
// bank, sum/round/saturate, border compare and output register). Throughput:
// one word per cycle while dst_stall is low, set by the four-stage pipeline.
// Each stage holds its word while the stage after it is full and stalled;
// a stage with a bubble still takes a new word, so dst_stall only backs up
// src_stall once all four stages are full.
// Reset empties the pipeline and loads the default borders
// (-500, 1500, -400, 1200).
module affine2d_compose_cull_color_unit
    import affcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  in_word_t             src_word,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output out_word_t            dst_word,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BORDER_W-1:0]  cfg_data
);

    localparam int NPROD = 12;
    localparam int NDOT = 6;
    localparam int SUM_W = 65;
    localparam int CMP_W = ((BORDER_W + COORD_FRAC_BITS > 32) ?
                            BORDER_W + COORD_FRAC_BITS : 32) + 1;
    localparam logic signed [SUM_W-1:0] HALF_C = SUM_W'(1) <<< (COORD_FRAC_BITS - 1);
    localparam logic [32:0] HALF_COL = 33'(1) << (COLOR_FRAC_BITS - 1);
    localparam logic [15:0] COLOR_ONE = 16'(1 << COLOR_FRAC_BITS);
    localparam logic [63:0] COLOR_ONES = {COLOR_ONE, COLOR_ONE, COLOR_ONE, COLOR_ONE};

    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [31:0] r;
        if (v > SUM_W'(signed'(32'h7FFFFFFF)))
            r = 32'h7FFFFFFF;
        else if (v < SUM_W'(signed'(32'h80000000)))
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // borders
    logic [BORDER_W-1:0] left_border_reg, right_border_reg;
    logic [BORDER_W-1:0] top_border_reg, bottom_border_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_border_reg   <= LEFT_BORDER_RST;
            right_border_reg  <= RIGHT_BORDER_RST;
            top_border_reg    <= TOP_BORDER_RST;
            bottom_border_reg <= BOTTOM_BORDER_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_LEFT:   left_border_reg   <= cfg_data;
                REG_RIGHT:  right_border_reg  <= cfg_data;
                REG_TOP:    top_border_reg    <= cfg_data;
                REG_BOTTOM: bottom_border_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // flow control
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic a_ready, b_ready, c_ready, d_ready;

    assign d_ready = !d_valid_reg || !dst_stall;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign src_stall = !a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= src_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                d_valid_reg <= c_valid_reg;
        end
    end

    // stage A: input register
    in_word_t a_word_reg;

    always_ff @(posedge clk)
    begin
        if (a_ready)
            a_word_reg <= src_word;
    end

    // stage B: decode and multiplier bank
    logic               b_has_par_next, b_mat_chg_next;
    logic [1:0]         b_mode_next, b_type_next, b_col_next;
    logic signed [63:0] b_prod_next [NPROD];
    logic [31:0]        b_cprod_next [4];

    logic               b_has_par_reg, b_mat_chg_reg;
    logic [1:0]         b_mode_reg, b_type_reg, b_col_reg;
    logic signed [63:0] b_prod_reg [NPROD];
    logic [31:0]        b_cprod_reg [4];
    logic [63:0]        b_lab_reg, b_lcd_reg, b_ltxy_reg, b_ptxy_reg;
    logic [63:0]        b_pcol_reg, b_lcol_reg;

    always_comb
    begin
        logic signed [31:0] pa, pb, pc, pd, la, lb, lc, ld, ltx, lty;
        logic [1:0] pt, lt;
        pa  = a_word_reg.parent_ab[63:32];
        pb  = a_word_reg.parent_ab[31:0];
        pc  = a_word_reg.parent_cd[63:32];
        pd  = a_word_reg.parent_cd[31:0];
        la  = a_word_reg.local_ab[63:32];
        lb  = a_word_reg.local_ab[31:0];
        lc  = a_word_reg.local_cd[63:32];
        ld  = a_word_reg.local_cd[31:0];
        ltx = a_word_reg.local_txy[63:32];
        lty = a_word_reg.local_txy[31:0];
        pt  = a_word_reg.parent_type;
        lt  = a_word_reg.local_type;

        b_has_par_next = a_word_reg.flags[FLAG_HAS_PAR];
        b_mat_chg_next = a_word_reg.flags[FLAG_MAT_CHG];

        if (!b_has_par_next || pt == TYPE_IDENT)
        begin
            b_mode_next = MODE_COPY;
            b_type_next = lt;
        end
        else if (pt == TYPE_TRANSLATE)
        begin
            b_mode_next = MODE_TRANS;
            b_type_next = (lt == TYPE_IDENT) ? TYPE_TRANSLATE : lt;
        end
        else
        begin
            b_mode_next = MODE_FULL;
            if (pt == TYPE_TSCALE)
                b_type_next = (lt == TYPE_GENERAL) ? TYPE_GENERAL : TYPE_TSCALE;
            else
                b_type_next = TYPE_GENERAL;
        end

        priority if (a_word_reg.flags[FLAG_USE_PAR])
            b_col_next = b_has_par_next ? COL_PARENT : COL_NONE;
        else if (a_word_reg.flags[FLAG_COL_CHG])
        begin
            if (a_word_reg.local_color == COLOR_ONES)
                b_col_next = b_has_par_next ? COL_PARENT : COL_LOCAL;
            else
                b_col_next = b_has_par_next ? COL_MUL : COL_LOCAL;
        end
        else
            b_col_next = COL_NONE;

        b_prod_next[0]  = 64'(pa) * 64'(la);
        b_prod_next[1]  = 64'(pb) * 64'(lc);
        b_prod_next[2]  = 64'(pa) * 64'(lb);
        b_prod_next[3]  = 64'(pb) * 64'(ld);
        b_prod_next[4]  = 64'(pc) * 64'(la);
        b_prod_next[5]  = 64'(pd) * 64'(lc);
        b_prod_next[6]  = 64'(pc) * 64'(lb);
        b_prod_next[7]  = 64'(pd) * 64'(ld);
        b_prod_next[8]  = 64'(pa) * 64'(ltx);
        b_prod_next[9]  = 64'(pb) * 64'(lty);
        b_prod_next[10] = 64'(pc) * 64'(ltx);
        b_prod_next[11] = 64'(pd) * 64'(lty);

        for (int k = 0; k < 4; k++)
            b_cprod_next[k] = 32'(a_word_reg.parent_color[63 - 16*k -: 16])
                            * 32'(a_word_reg.local_color[63 - 16*k -: 16]);
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_has_par_reg <= b_has_par_next;
            b_mat_chg_reg <= b_mat_chg_next;
            b_mode_reg    <= b_mode_next;
            b_type_reg    <= b_type_next;
            b_col_reg     <= b_col_next;
            b_prod_reg    <= b_prod_next;
            b_cprod_reg   <= b_cprod_next;
            b_lab_reg     <= a_word_reg.local_ab;
            b_lcd_reg     <= a_word_reg.local_cd;
            b_ltxy_reg    <= a_word_reg.local_txy;
            b_ptxy_reg    <= a_word_reg.parent_txy;
            b_pcol_reg    <= a_word_reg.parent_color;
            b_lcol_reg    <= a_word_reg.local_color;
        end
    end

    // stage C: sum, round, add translation, saturate; colour select
    logic        c_mat_chg_next, c_col_upd_next;
    logic [63:0] c_ab_next, c_cd_next, c_txy_next, c_col_next;
    logic [1:0]  c_type_next;

    logic        c_mat_chg_reg, c_has_par_reg, c_col_upd_reg;
    logic [63:0] c_ab_reg, c_cd_reg, c_txy_reg, c_col_reg;
    logic [1:0]  c_type_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] tadd;
        logic [31:0]             dot [NDOT];
        logic [63:0]             tr_txy;
        logic [32:0]             cv;
        logic [63:0]             cmul;

        for (int i = 0; i < NDOT; i++)
        begin
            if (i == 4)
                tadd = SUM_W'(signed'(b_ptxy_reg[63:32]));
            else if (i == 5)
                tadd = SUM_W'(signed'(b_ptxy_reg[31:0]));
            else
                tadd = '0;
            sum = SUM_W'(b_prod_reg[2*i]) + SUM_W'(b_prod_reg[2*i + 1]) + HALF_C;
            sum = (sum >>> COORD_FRAC_BITS) + tadd;
            dot[i] = sat32(sum);
        end

        tr_txy = {sat32(SUM_W'(signed'(b_ltxy_reg[63:32]))
                        + SUM_W'(signed'(b_ptxy_reg[63:32]))),
                  sat32(SUM_W'(signed'(b_ltxy_reg[31:0]))
                        + SUM_W'(signed'(b_ptxy_reg[31:0])))};

        c_mat_chg_next = b_mat_chg_reg;
        if (!b_mat_chg_reg)
        begin
            c_ab_next   = '0;
            c_cd_next   = '0;
            c_txy_next  = '0;
            c_type_next = TYPE_IDENT;
        end
        else
        begin
            c_type_next = b_type_reg;
            unique case (b_mode_reg)
                MODE_COPY:
                begin
                    c_ab_next  = b_lab_reg;
                    c_cd_next  = b_lcd_reg;
                    c_txy_next = b_ltxy_reg;
                end
                MODE_TRANS:
                begin
                    c_ab_next  = b_lab_reg;
                    c_cd_next  = b_lcd_reg;
                    c_txy_next = tr_txy;
                end
                default:
                begin
                    c_ab_next  = {dot[0], dot[1]};
                    c_cd_next  = {dot[2], dot[3]};
                    c_txy_next = {dot[4], dot[5]};
                end
            endcase
        end

        for (int k = 0; k < 4; k++)
        begin
            cv = (33'(b_cprod_reg[k]) + HALF_COL) >> COLOR_FRAC_BITS;
            cmul[63 - 16*k -: 16] = (cv > 33'h0FFFF) ? 16'hFFFF : cv[15:0];
        end

        unique case (b_col_reg)
            COL_PARENT:
            begin
                c_col_upd_next = 1'b1;
                c_col_next     = b_pcol_reg;
            end
            COL_LOCAL:
            begin
                c_col_upd_next = 1'b1;
                c_col_next     = b_lcol_reg;
            end
            COL_MUL:
            begin
                c_col_upd_next = 1'b1;
                c_col_next     = cmul;
            end
            default:
            begin
                c_col_upd_next = 1'b0;
                c_col_next     = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            c_mat_chg_reg <= c_mat_chg_next;
            c_has_par_reg <= b_has_par_reg;
            c_ab_reg      <= c_ab_next;
            c_cd_reg      <= c_cd_next;
            c_txy_reg     <= c_txy_next;
            c_type_reg    <= c_type_next;
            c_col_upd_reg <= c_col_upd_next;
            c_col_reg     <= c_col_next;
        end
    end

    // stage D: border window and output register
    out_word_t d_word_next, d_word_reg;

    always_comb
    begin
        logic signed [CMP_W-1:0] tx, ty, lo_x, hi_x, lo_y, hi_y;
        logic in_window;
        tx   = CMP_W'(signed'(c_txy_reg[63:32]));
        ty   = CMP_W'(signed'(c_txy_reg[31:0]));
        lo_x = CMP_W'(signed'(left_border_reg)) <<< COORD_FRAC_BITS;
        hi_x = CMP_W'(signed'(right_border_reg)) <<< COORD_FRAC_BITS;
        lo_y = CMP_W'(signed'(top_border_reg)) <<< COORD_FRAC_BITS;
        hi_y = CMP_W'(signed'(bottom_border_reg)) <<< COORD_FRAC_BITS;
        in_window = (tx >= lo_x) && (tx <= hi_x) && (ty >= lo_y) && (ty <= hi_y);

        d_word_next.matrix_updated = c_mat_chg_reg;
        d_word_next.comp_ab        = c_ab_reg;
        d_word_next.comp_cd        = c_cd_reg;
        d_word_next.comp_txy       = c_txy_reg;
        d_word_next.comp_type      = c_type_reg;
        d_word_next.reject         = c_mat_chg_reg && c_has_par_reg && !in_window;
        d_word_next.color_updated  = c_col_upd_reg;
        d_word_next.color_out      = c_col_reg;
    end

    always_ff @(posedge clk)
    begin
        if (d_ready)
            d_word_reg <= d_word_next;
    end

    assign dst_valid = d_valid_reg;
    assign dst_word  = d_word_reg;

endmodule
